FILE: rtl/core/llpw_pkg.sv
// Shared types and constants for the laser line pixel to world block.
package llpw_pkg;

	localparam int NUM_W  = 64;	// |d| * |gain|
	localparam int DEN_W  = 34;	// |pole - d|
	localparam int QUO_W  = 32;	// height quotient bits kept
	localparam int RAD_W  = 66;	// hw^2 in Q32.32
	localparam int ROOT_W = 33;	// hw in Q16.16
	localparam int A_W    = 47;	// |column offset| * pitch, Q16.16
	localparam int K_W    = 48;	// |hw * inv_focal - 1|, Q16.16

	localparam logic [K_W-1:0] ONE_Q16 = 48'd65536;

	typedef enum logic [2:0] {
		CFG_ROW_CENTER,
		CFG_COL_CENTER,
		CFG_HEIGHT_GAIN,
		CFG_POLE_ROW_OFFSET,
		CFG_BASE_HEIGHT,
		CFG_LATERAL_OFFSET_SQ,
		CFG_INV_FOCAL,
		CFG_SCALE_U
	} cfg_index_t;

	typedef struct packed {
		logic [11:0] column;
		logic [11:0] row;
		logic        line_end;
	} point_t;

	typedef struct packed {
		logic signed [31:0] x_position;
		logic signed [31:0] height;
		logic               error_flag;
		logic               line_end_out;
	} result_t;

	typedef struct packed {
		logic [A_W-1:0] a_mag;
		logic           a_neg;
		logic           h_neg;
		logic           zero_den;
		logic           line_end;
	} div_side_t;

	typedef struct packed {
		logic [A_W-1:0] a_mag;
		logic           a_neg;
		logic [31:0]    height;
		logic           err;
		logic           zero_den;
		logic           line_end;
	} sqrt_side_t;

endpackage

FILE: rtl/core/llpw_div.sv
// Pipelined restoring divider: one quotient bit per stage, with overflow check.
module llpw_div #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [llpw_pkg::NUM_W-1:0]    num,
	input  logic [llpw_pkg::DEN_W-1:0]    den,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          out_valid,
	output logic [llpw_pkg::QUO_W-1:0]    quo,
	output logic                          ovf,
	output logic [SIDE_W-1:0]             side_out
);

	localparam int NW = llpw_pkg::NUM_W;
	localparam int DW = llpw_pkg::DEN_W;
	localparam int QW = llpw_pkg::QUO_W;
	localparam int TW = DW + QW;

	logic              v_s   [0:QW];
	logic [NW-1:0]     rem_s [0:QW];
	logic [QW-1:0]     q_s   [0:QW];
	logic              ovf_s [0:QW];
	logic [DW-1:0]     den_s [0:QW];
	logic [SIDE_W-1:0] sd_s  [0:QW];

	// entry stage: quotient would need more than QW bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			q_s[0]   <= '0;
			ovf_s[0] <= {{(TW-NW){1'b0}}, num} >= {den, {QW{1'b0}}};
			den_s[0] <= den;
			sd_s[0]  <= side_in;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int B = QW - 1 - i;
		logic [TW-1:0] trial;
		logic          ge;

		assign trial = {{QW{1'b0}}, den_s[i]} << B;
		assign ge    = {{(TW-NW){1'b0}}, rem_s[i]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - trial[NW-1:0] : rem_s[i];
				q_s[i+1]   <= q_s[i] | (ge ? (QW'(1) << B) : '0);
				ovf_s[i+1] <= ovf_s[i];
				den_s[i+1] <= den_s[i];
				sd_s[i+1]  <= sd_s[i];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = q_s[QW];
	assign ovf       = ovf_s[QW];
	assign side_out  = sd_s[QW];

endmodule

FILE: rtl/core/llpw_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module llpw_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [llpw_pkg::RAD_W-1:0]    rad,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          out_valid,
	output logic [llpw_pkg::ROOT_W-1:0]   root,
	output logic [SIDE_W-1:0]             side_out
);

	localparam int RW = llpw_pkg::RAD_W;
	localparam int QW = llpw_pkg::ROOT_W;
	localparam int TW = RW + 2;

	logic              v_s   [0:QW];
	logic [RW-1:0]     rem_s [0:QW];
	logic [QW-1:0]     r_s   [0:QW];
	logic [SIDE_W-1:0] sd_s  [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rad;
			r_s[0]   <= '0;
			sd_s[0]  <= side_in;
		end
	end

	// rem holds rad - r^2; (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int B = QW - 1 - i;
		logic [TW-1:0] trial;
		logic          ge;

		assign trial = ({{(TW-QW){1'b0}}, r_s[i]} << (B + 1)) + (TW'(1) << (2 * B));
		assign ge    = {2'b00, rem_s[i]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - trial[RW-1:0] : rem_s[i];
				r_s[i+1]   <= r_s[i] | (ge ? (QW'(1) << B) : '0);
				sd_s[i+1]  <= sd_s[i];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign root      = r_s[QW];
	assign side_out  = sd_s[QW];

endmodule

FILE: rtl/core/laser_line_pixel_to_world.sv
// Laser line pixel to world: each point passes through a registered pipeline to the result word.
// Throughput one word per cycle while the skid entry is empty; the divider's 32 steps and
// the square root's 33 steps set the depth, each step one compare and subtract.
// A two-entry output (register plus skid) keeps point_ready a register.
// arst_n clears all valid bits and loads register reset values (pole offset 1.0).
module laser_line_pixel_to_world (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	output logic                 point_ready,
	input  llpw_pkg::point_t     point,
	output logic                 result_valid,
	input  logic                 result_ready,
	output llpw_pkg::result_t    result,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int A_W    = llpw_pkg::A_W;
	localparam int K_W    = llpw_pkg::K_W;
	localparam int ROOT_W = llpw_pkg::ROOT_W;
	localparam int RAD_W  = llpw_pkg::RAD_W;
	localparam int QUO_W  = llpw_pkg::QUO_W;
	localparam int DEN_W  = llpw_pkg::DEN_W;
	localparam int NUM_W  = llpw_pkg::NUM_W;

	// configuration registers
	logic [31:0] row_center_q, col_center_q, height_gain_q, pole_row_offset_q;
	logic [31:0] base_height_q, lateral_offset_sq_q;
	logic [30:0] inv_focal_q, scale_u_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_center_q        <= '0;
			col_center_q        <= '0;
			height_gain_q       <= '0;
			pole_row_offset_q   <= 32'd65536;
			base_height_q       <= '0;
			lateral_offset_sq_q <= '0;
			inv_focal_q         <= '0;
			scale_u_q           <= '0;
		end else if (cfg_we) begin
			case (llpw_pkg::cfg_index_t'(cfg_index))
				llpw_pkg::CFG_ROW_CENTER:        row_center_q        <= cfg_data;
				llpw_pkg::CFG_COL_CENTER:        col_center_q        <= cfg_data;
				llpw_pkg::CFG_HEIGHT_GAIN:       height_gain_q       <= cfg_data;
				llpw_pkg::CFG_POLE_ROW_OFFSET:   pole_row_offset_q   <= cfg_data;
				llpw_pkg::CFG_BASE_HEIGHT:       base_height_q       <= cfg_data;
				llpw_pkg::CFG_LATERAL_OFFSET_SQ: lateral_offset_sq_q <= cfg_data;
				llpw_pkg::CFG_INV_FOCAL:         inv_focal_q         <= cfg_data[30:0];
				llpw_pkg::CFG_SCALE_U:           scale_u_q           <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless the skid entry is occupied
	logic skid_v_q, res_v_q, en;
	assign en          = !skid_v_q;
	assign point_ready = en;

	// stage 1: offsets, signs and magnitudes
	logic [34:0] d_c, den_c, cc_c;
	logic [31:0] dmag_c, gmag_c, ccmag_c;
	logic [34:0] denabs_c;

	assign d_c      = {7'd0, point.row, 16'd0} - {{3{row_center_q[31]}}, row_center_q};
	assign den_c    = {{3{pole_row_offset_q[31]}}, pole_row_offset_q} - d_c;
	assign cc_c     = {7'd0, point.column, 16'd0} - {{3{col_center_q[31]}}, col_center_q};
	assign dmag_c   = d_c[34] ? 32'(35'd0 - d_c) : d_c[31:0];
	assign gmag_c   = height_gain_q[31] ? 32'd0 - height_gain_q : height_gain_q;
	assign ccmag_c  = cc_c[34] ? 32'(35'd0 - cc_c) : cc_c[31:0];
	assign denabs_c = den_c[34] ? 35'd0 - den_c : den_c;

	logic             v_s1, v_s2;
	logic [31:0]      dmag_s1, gmag_s1, ccmag_s1;
	logic [DEN_W-1:0] denmag_s1, denmag_s2;
	logic             hneg_s1, zden_s1, cneg_s1, le_s1;
	logic             hneg_s2, zden_s2, cneg_s2, le_s2;
	logic [NUM_W-1:0] nprod_s2;
	logic [A_W-1:0]   amag_s2;
	logic [62:0]      aprod_c;

	assign aprod_c = 63'(ccmag_s1) * 63'(scale_u_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= point_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s1   <= dmag_c;
			gmag_s1   <= gmag_c;
			ccmag_s1  <= ccmag_c;
			denmag_s1 <= denabs_c[DEN_W-1:0];
			hneg_s1   <= d_c[34] ^ height_gain_q[31] ^ den_c[34];
			zden_s1   <= den_c == '0;
			cneg_s1   <= cc_c[34];
			le_s1     <= point.line_end;

			nprod_s2  <= NUM_W'(dmag_s1) * NUM_W'(gmag_s1);
			amag_s2   <= aprod_c[62:16];
			denmag_s2 <= denmag_s1;
			hneg_s2   <= hneg_s1;
			zden_s2   <= zden_s1;
			cneg_s2   <= cneg_s1;
			le_s2     <= le_s1;
		end
	end

	// height division
	llpw_pkg::div_side_t div_in_side, div_out_side;
	logic                div_v;
	logic [QUO_W-1:0]    div_quo;
	logic                div_ovf;

	assign div_in_side = '{a_mag: amag_s2, a_neg: cneg_s2, h_neg: hneg_s2,
		zero_den: zden_s2, line_end: le_s2};

	llpw_div #(
		.SIDE_W($bits(llpw_pkg::div_side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.num      (nprod_s2),
		.den      (denmag_s2),
		.side_in  (div_in_side),
		.out_valid(div_v),
		.quo      (div_quo),
		.ovf      (div_ovf),
		.side_out (div_out_side)
	);

	// stage 3: saturate height
	logic        hn_c, hsat_c;
	logic [31:0] hlim_c, hmag_c;

	assign hn_c   = div_out_side.h_neg && (div_quo != '0 || div_ovf);
	assign hlim_c = hn_c ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign hsat_c = div_ovf || (div_quo > hlim_c);
	assign hmag_c = hsat_c ? hlim_c : div_quo;

	logic             v_s3, v_s4, v_s5, v_s6;
	logic [31:0]      hv_s3, hv_s4, hv_s5, hv_s6;
	logic             err_s3, err_s4, err_s5, err_s6;
	logic [A_W-1:0]   amag_s3, amag_s4, amag_s5, amag_s6;
	logic             cneg_s3, cneg_s4, cneg_s5, cneg_s6;
	logic             zden_s3, zden_s4, zden_s5, zden_s6;
	logic             le_s3, le_s4, le_s5, le_s6;
	logic [32:0]      m_s4;
	logic [RAD_W-1:0] sq_s5, rad_s6;
	logic [32:0]      hsum_c;

	assign hsum_c = {base_height_q[31], base_height_q} + {hv_s3[31], hv_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s3 <= div_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hv_s3   <= hn_c ? 32'd0 - hmag_c : hmag_c;
			err_s3  <= hsat_c;
			amag_s3 <= div_out_side.a_mag;
			cneg_s3 <= div_out_side.a_neg;
			zden_s3 <= div_out_side.zero_den;
			le_s3   <= div_out_side.line_end;

			m_s4    <= hsum_c[32] ? 33'd0 - hsum_c : hsum_c;
			hv_s4   <= hv_s3;
			err_s4  <= err_s3;
			amag_s4 <= amag_s3;
			cneg_s4 <= cneg_s3;
			zden_s4 <= zden_s3;
			le_s4   <= le_s3;

			sq_s5   <= RAD_W'(m_s4) * RAD_W'(m_s4);
			hv_s5   <= hv_s4;
			err_s5  <= err_s4;
			amag_s5 <= amag_s4;
			cneg_s5 <= cneg_s4;
			zden_s5 <= zden_s4;
			le_s5   <= le_s4;

			rad_s6  <= sq_s5 + {2'b00, lateral_offset_sq_q, 32'd0};
			hv_s6   <= hv_s5;
			err_s6  <= err_s5;
			amag_s6 <= amag_s5;
			cneg_s6 <= cneg_s5;
			zden_s6 <= zden_s5;
			le_s6   <= le_s5;
		end
	end

	// hw = floor(sqrt(hw^2))
	llpw_pkg::sqrt_side_t sq_in_side, sq_out_side;
	logic                 sq_v;
	logic [ROOT_W-1:0]    sq_root;

	assign sq_in_side = '{a_mag: amag_s6, a_neg: cneg_s6, height: hv_s6, err: err_s6,
		zero_den: zden_s6, line_end: le_s6};

	llpw_sqrt #(
		.SIDE_W($bits(llpw_pkg::sqrt_side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.rad      (rad_s6),
		.side_in  (sq_in_side),
		.out_valid(sq_v),
		.root     (sq_root),
		.side_out (sq_out_side)
	);

	// stages 7..11: k, then a*|k| from partial products with operands split at bit 24
	logic             v_s7, v_s8, v_s9, v_s10, v_s11;
	logic [63:0]      kp_s7;
	logic [K_W-1:0]   kmag_s8;
	logic             kneg_s8;
	logic [K_W-1:0]   kq_c;
	logic [47:0]      pll_s9, plh_s9, phl_s9, phh_s9, pll_s10, phh_s10;
	logic [48:0]      mid_s10;
	logic [95:0]      full_s11;
	logic             xn_s9, xn_s10, xn_s11;
	logic [A_W-1:0]   amag_s7, amag_s8;
	logic             cneg_s7, cneg_s8;
	llpw_pkg::sqrt_side_t sd_s7, sd_s8, sd_s9, sd_s10, sd_s11;

	assign kq_c = kp_s7[63:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s7  <= sq_v;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kp_s7   <= 64'(sq_root) * 64'(inv_focal_q);
			amag_s7 <= sq_out_side.a_mag;
			cneg_s7 <= sq_out_side.a_neg;
			sd_s7   <= sq_out_side;

			kneg_s8 <= kq_c < llpw_pkg::ONE_Q16;
			kmag_s8 <= (kq_c < llpw_pkg::ONE_Q16) ? llpw_pkg::ONE_Q16 - kq_c
				: kq_c - llpw_pkg::ONE_Q16;
			amag_s8 <= amag_s7;
			cneg_s8 <= cneg_s7;
			sd_s8   <= sd_s7;

			pll_s9 <= 48'(amag_s8[23:0]) * 48'(kmag_s8[23:0]);
			plh_s9 <= 48'(amag_s8[23:0]) * 48'(kmag_s8[47:24]);
			phl_s9 <= 48'(amag_s8[46:24]) * 48'(kmag_s8[23:0]);
			phh_s9 <= 48'(amag_s8[46:24]) * 48'(kmag_s8[47:24]);
			xn_s9  <= cneg_s8 ^ kneg_s8;
			sd_s9  <= sd_s8;

			mid_s10 <= {1'b0, plh_s9} + {1'b0, phl_s9};
			pll_s10 <= pll_s9;
			phh_s10 <= phh_s9;
			xn_s10  <= xn_s9;
			sd_s10  <= sd_s9;

			full_s11 <= ({48'd0, phh_s10} << 48) + ({47'd0, mid_s10} << 24) + {48'd0, pll_s10};
			xn_s11   <= xn_s10;
			sd_s11   <= sd_s10;
		end
	end

	// final: drop fraction, sign, saturate, zero-denominator override
	logic [79:0]       mx_c, xlim_c;
	logic              xn_c, xsat_c;
	logic [31:0]       xmag_c;
	llpw_pkg::result_t res_c, res_q, skid_q;

	assign mx_c   = full_s11[95:16];
	assign xn_c   = xn_s11 && (mx_c != '0);
	assign xlim_c = xn_c ? 80'h8000_0000 : 80'h7FFF_FFFF;
	assign xsat_c = mx_c > xlim_c;
	assign xmag_c = xsat_c ? xlim_c[31:0] : mx_c[31:0];

	always_comb begin
		res_c.line_end_out = sd_s11.line_end;
		if (sd_s11.zero_den) begin
			res_c.x_position = '0;
			res_c.height     = '0;
			res_c.error_flag = 1'b1;
		end else begin
			res_c.x_position = xn_c ? 32'd0 - xmag_c : xmag_c;
			res_c.height     = sd_s11.height;
			res_c.error_flag = sd_s11.err | xsat_c;
		end
	end

	// output word plus skid entry
	logic push, pop;
	assign push = en && v_s11;
	assign pop  = res_v_q && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !res_v_q) begin
			res_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !res_v_q) begin
			res_q <= skid_v_q ? skid_q : res_c;
		end else if (push) begin
			skid_q <= res_c;
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

endmodule
